>>> rtl/rgb_led_ring_pattern_engine_macros.svh
// Assertion macros for the LED ring pattern engine.
`ifndef RGB_LED_RING_PATTERN_ENGINE_MACROS_SVH
`define RGB_LED_RING_PATTERN_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define RLPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlpe: implication check failed");
`define RLPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlpe: next-cycle check failed");
`else
`define RLPE_ASSERT_IMP(lbl, ante, cons)
`define RLPE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/rlpe_pkg.sv
package rlpe_pkg;

  localparam int LED_COUNT  = 16;
  localparam int LED_IDX_W  = $clog2(LED_COUNT);
  localparam int CHANNELS   = 4;
  localparam int NUM_CH     = 4;
  localparam int LEVEL_W    = 13;
  localparam int HEADING_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [3:0] MODE_STOP      = 4'd0;
  localparam logic [3:0] MODE_CLEAR     = 4'd1;
  localparam logic [3:0] MODE_BATTERY   = 4'd2;
  localparam logic [3:0] MODE_ANGLE     = 4'd3;
  localparam logic [3:0] MODE_FADEANGLE = 4'd4;
  localparam logic [3:0] MODE_GRADIENT  = 4'd5;
  localparam logic [3:0] MODE_ROTATE    = 4'd6;
  localparam logic [3:0] MODE_ERROR     = 4'd7;
  localparam logic [3:0] MODE_EMERGENCY = 4'd8;
  localparam logic [3:0] MODE_BUSY      = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE3 = 3'd6;

  localparam logic [2:0] PAL_GREY      = 3'd0;
  localparam logic [2:0] PAL_STOPLIGHT = 3'd1;
  localparam logic [2:0] PAL_BLUERED   = 3'd2;
  localparam logic [2:0] PAL_RED       = 3'd3;
  localparam logic [2:0] PAL_GREEN     = 3'd4;
  localparam logic [2:0] PAL_BLUE      = 3'd5;

  localparam logic [7:0] EMERGENCY_PERIOD = 8'd25;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t                 col;
    logic                 act;
    logic [LED_IDX_W-1:0] apos;
    logic [LED_IDX_W-1:0] spos;
  } chan_t;

  typedef struct packed {
    logic                 paint;
    logic                 blink_on;
    logic                 blink_off;
    logic                 busy_wrap;
    logic [LED_IDX_W-1:0] busy_idx;
    logic [7:0]           busy_val;
    logic                 grad_new;
  } tick_t;

  function automatic rgb_t map_color(input logic [2:0] pal, input logic [LEVEL_W-1:0] lvl);
    rgb_t               c;
    logic [LEVEL_W-1:0] hi;
    c  = '0;
    hi = lvl - 13'd2048;
    unique case (pal)
      PAL_GREY: begin
        c.r = lvl[11:4];
        c.g = lvl[11:4];
        c.b = lvl[11:4];
      end
      PAL_STOPLIGHT: begin
        if (lvl < 13'd2048) begin
          c.r = lvl[10:3];
          c.g = 8'd255;
        end else begin
          c.r = 8'd255;
          c.g = 8'd255 - hi[10:3];
        end
      end
      PAL_BLUERED: begin
        c.r = lvl[11:4];
        c.b = 8'd255 - lvl[11:4];
      end
      PAL_RED:   c.r = lvl[11:4];
      PAL_GREEN: c.g = lvl[11:4];
      PAL_BLUE:  c.b = lvl[11:4];
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] reduce_deg(input logic [HEADING_W-1:0] h);
    logic [11:0] u;
    u = {h[HEADING_W-1], h} + 12'd1080;
    if (u >= 12'd1440) u = u - 12'd1440;
    if (u >= 12'd720)  u = u - 12'd720;
    if (u >= 12'd360)  u = u - 12'd360;
    return u[8:0];
  endfunction

  function automatic logic [4:0] ring_pos(input logic [8:0] deg);
    logic [8:0]  a;
    logic [13:0] p;
    a = 9'd360 - deg;
    p = 14'(a) * 14'd23 + 14'd253;
    return p[13:9];
  endfunction

  function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c,
                                         input logic [7:0] w);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, c - w};
    if (c <= w) begin
      s = {1'b0, acc};
    end
    return s[8] ? 8'd255 : s[7:0];
  endfunction

  function automatic logic [7:0] ramp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [2:0] j);
    logic [8:0]         dp;
    logic signed [6:0]  s;
    logic signed [3:0]  js;
    logic signed [10:0] pr;
    dp = {1'b0, b} - {1'b0, a} + 9'd256;
    s  = signed'({1'b0, dp[8:3]}) - 7'sd32;
    js = signed'({1'b0, j});
    pr = s * js;
    return a + pr[7:0];
  endfunction

endpackage

>>> rtl/rlpe_in_if.sv
interface rlpe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rlpe_pkg::LEVEL_W-1:0]         level0;
  logic [rlpe_pkg::LEVEL_W-1:0]         level1;
  logic [rlpe_pkg::LEVEL_W-1:0]         level2;
  logic [rlpe_pkg::LEVEL_W-1:0]         level3;
  logic signed [rlpe_pkg::HEADING_W-1:0] heading0;
  logic signed [rlpe_pkg::HEADING_W-1:0] heading1;
  logic signed [rlpe_pkg::HEADING_W-1:0] heading2;
  logic signed [rlpe_pkg::HEADING_W-1:0] heading3;

  modport source (output valid, level0, level1, level2, level3,
                  heading0, heading1, heading2, heading3, input ready);
  modport sink (input valid, level0, level1, level2, level3,
                heading0, heading1, heading2, heading3, output ready);
endinterface

>>> rtl/rlpe_out_if.sv
interface rlpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlpe_pkg::LED_IDX_W-1:0] led_index;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic                           last_led;

  modport source (output valid, led_index, red, green, blue, last_led, input ready);
  modport sink (input valid, led_index, red, green, blue, last_led, output ready);
endinterface

>>> rtl/rlpe_led_ram.sv
module rlpe_led_ram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  logic                           rd_en,
  input  logic [rlpe_pkg::LED_IDX_W-1:0] rd_addr,
  output rlpe_pkg::rgb_t                 rd_data,
  input  logic                           wr_en,
  input  logic [rlpe_pkg::LED_IDX_W-1:0] wr_addr,
  input  rlpe_pkg::rgb_t                 wr_data
);

  rlpe_pkg::rgb_t                   mem [rlpe_pkg::LED_COUNT];
  logic [rlpe_pkg::LED_COUNT-1:0]   vld_r;
  rlpe_pkg::rgb_t                   rd_data_r;

  // An entry that has not been written since the last clear reads as black.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/rlpe_setup.sv
module rlpe_setup (
  input  logic [rlpe_pkg::NUM_CH-1:0][rlpe_pkg::LEVEL_W-1:0]   lvl,
  input  logic [rlpe_pkg::NUM_CH-1:0][rlpe_pkg::HEADING_W-1:0] hd,
  input  logic [rlpe_pkg::NUM_CH-1:0][2:0]                     pal,
  output rlpe_pkg::chan_t [rlpe_pkg::NUM_CH-1:0]               chan
);

  logic [rlpe_pkg::NUM_CH-1:0][4:0] rp;

  always_comb begin
    for (int c = 0; c < rlpe_pkg::NUM_CH; c++) begin
      rp[c]        = rlpe_pkg::ring_pos(rlpe_pkg::reduce_deg(hd[c]));
      chan[c].col  = rlpe_pkg::map_color(pal[c], lvl[c]);
      chan[c].act  = ~lvl[c][rlpe_pkg::LEVEL_W-1];
      chan[c].apos = rp[c][4] ? '0 : rp[c][3:0];
      chan[c].spos = rp[c][3:0] + 4'd13;
    end
  end

endmodule

>>> rtl/rlpe_pixel.sv
module rlpe_pixel (
  input  logic [3:0]                             mode,
  input  logic [6:0]                             battery,
  input  rlpe_pkg::tick_t                        tick,
  input  rlpe_pkg::chan_t [rlpe_pkg::NUM_CH-1:0] chan,
  input  logic [rlpe_pkg::LED_IDX_W-1:0]         oidx,
  input  rlpe_pkg::rgb_t                         old,
  output rlpe_pkg::rgb_t                         nxt
);

  logic [12:0]                    bprod;
  logic [3:0]                     btop;
  logic [6:0]                     blen;
  logic [7:0]                     btwo;
  logic [rlpe_pkg::LED_IDX_W-1:0] k;
  logic [1:0]                     wdist;
  logic [7:0]                     w;
  logic [rlpe_pkg::LED_IDX_W-1:0] mir;
  logic [2:0]                     jj;
  rlpe_pkg::rgb_t                 c1;
  rlpe_pkg::rgb_t                 c2;

  always_comb begin
    bprod = 13'(battery) * 13'd41;
    btop  = (bprod[12:8] > 5'd15) ? 4'd15 : bprod[11:8];
    blen  = (battery > 7'd10) ? battery - 7'd10 : battery;
    btwo  = {blen, 1'b0};
    mir   = 4'd0 - oidx;
    jj    = oidx[3] ? mir[2:0] : oidx[2:0];
    c1    = chan[0].col;
    c2    = chan[1].col;
    k     = '0;
    wdist = '0;
    w     = '0;
    nxt   = old;
    unique case (mode)
      rlpe_pkg::MODE_CLEAR: nxt = '0;
      rlpe_pkg::MODE_BATTERY: begin
        nxt = '0;
        if (oidx <= btop) begin
          nxt.r = 8'd255 - btwo;
          nxt.g = btwo;
        end
      end
      rlpe_pkg::MODE_ANGLE: begin
        nxt = '0;
        for (int c = 0; c < rlpe_pkg::CHANNELS; c++) begin
          if (chan[c].act && (chan[c].apos == oidx)) begin
            nxt = chan[c].col;
          end
        end
      end
      rlpe_pkg::MODE_FADEANGLE: begin
        nxt = '0;
        for (int c = 0; c < rlpe_pkg::CHANNELS; c++) begin
          k     = oidx - chan[c].spos;
          wdist = (k >= 4'd3) ? 2'(k - 4'd3) : 2'(4'd3 - k);
          w     = {wdist, 6'b0};
          if (chan[c].act && (k < 4'd7)) begin
            nxt.r = rlpe_pkg::sat_acc(nxt.r, chan[c].col.r, w);
            nxt.g = rlpe_pkg::sat_acc(nxt.g, chan[c].col.g, w);
            nxt.b = rlpe_pkg::sat_acc(nxt.b, chan[c].col.b, w);
          end
        end
      end
      rlpe_pkg::MODE_GRADIENT: begin
        if (tick.grad_new) begin
          if (oidx == 4'd8) begin
            nxt = c2;
          end else begin
            nxt.r = rlpe_pkg::ramp(c1.r, c2.r, jj);
            nxt.g = rlpe_pkg::ramp(c1.g, c2.g, jj);
            nxt.b = rlpe_pkg::ramp(c1.b, c2.b, jj);
          end
        end
      end
      rlpe_pkg::MODE_ERROR: begin
        if (tick.blink_on) begin
          nxt.r = 8'd255;
          nxt.g = 8'd128;
        end
        if (tick.blink_off) begin
          nxt.g = 8'd0;
        end
      end
      rlpe_pkg::MODE_EMERGENCY: begin
        if (tick.paint) begin
          if (oidx[0]) begin
            nxt.b = 8'd255;
          end else begin
            nxt.r = 8'd255;
          end
        end
      end
      rlpe_pkg::MODE_BUSY: begin
        if (tick.busy_wrap) begin
          nxt = '0;
        end else if (oidx == tick.busy_idx) begin
          nxt.g = tick.busy_val;
        end
      end
      default: nxt = old;
    endcase
  end

endmodule

>>> rtl/rgb_led_ring_pattern_engine.sv
// RGB LED ring pattern engine.
// The input channel takes one word per frame tick: four levels and four
// headings. For each tick the block updates its ring of 16 colours according
// to the mode register and sends 16 result words on the output channel, LED 0
// first, with last_led set on LED 15. The configuration port writes one
// register per cycle; the user must only use it while no tick is in progress,
// as the block itself does not enforce this. For each tick the block first
// latches the word, then maps levels and angles, then walks the LEDs in turn;
// each colour is read from the LED store, modified and written back.
// The next word is accepted once the last LED has been written. Rotation
// moves a base pointer rather than the data. While the receiver holds ready
// low the walk pauses with the next colour waiting; nothing is lost or
// repeated. Reset, and any write to the mode register, blanks all LEDs and
// clears the tick counters.
`include "rgb_led_ring_pattern_engine_macros.svh"

module rgb_led_ring_pattern_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  rlpe_in_if.sink                         in_chan,
  rlpe_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [rlpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CALC  = 4'b1000
  } st_t;

  st_t                                               st_r;
  st_t                                               st_nxt;
  logic [3:0]                                        mode_r;
  logic [7:0]                                        period_r;
  logic [6:0]                                        bat_r;
  logic [rlpe_pkg::NUM_CH-1:0][2:0]                  pal_r;
  logic [7:0]                                        phase_r;
  logic [7:0]                                        phase_nxt;
  logic [7:0]                                        rot_r;
  logic [7:0]                                        rot_nxt;
  logic [rlpe_pkg::LEVEL_W-1:0]                      prev_a_r;
  logic [rlpe_pkg::LEVEL_W-1:0]                      prev_b_r;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    base_r;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    delta_r;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    delta_nxt;
  rlpe_pkg::tick_t                                   tick_r;
  rlpe_pkg::tick_t                                   tick_nxt;
  logic [rlpe_pkg::NUM_CH-1:0][rlpe_pkg::LEVEL_W-1:0]   lvl_r;
  logic [rlpe_pkg::NUM_CH-1:0][rlpe_pkg::HEADING_W-1:0] hd_r;
  rlpe_pkg::chan_t [rlpe_pkg::NUM_CH-1:0]            chan_r;
  rlpe_pkg::chan_t [rlpe_pkg::NUM_CH-1:0]            chan_nxt;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    led_r;
  logic                                              out_valid_r;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    out_idx_r;
  rlpe_pkg::rgb_t                                    out_col_r;
  logic                                              out_last_r;

  logic                                              in_fire;
  logic                                              adv;
  logic                                              mode_wr;
  logic                                              do_shift;
  logic [7:0]                                        per;
  logic [7:0]                                        mag;
  logic [7:0]                                        rot_inc;
  logic [7:0]                                        ph1;
  logic [7:0]                                        ph_sat;
  logic                                              grad_new;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    phys;
  logic [rlpe_pkg::LED_IDX_W-1:0]                    oidx;
  rlpe_pkg::rgb_t                                    rd_data;
  rlpe_pkg::rgb_t                                    new_col;

  assign in_chan.ready = (st_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign adv           = (st_r == ST_CALC) && (!out_valid_r || out_chan.ready);
  assign mode_wr       = cfg_we && (cfg_index == rlpe_pkg::REG_MODE);
  assign phys          = led_r + base_r;
  assign oidx          = led_r + delta_r;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.led_index = out_idx_r;
  assign out_chan.red       = out_col_r.r;
  assign out_chan.green     = out_col_r.g;
  assign out_chan.blue      = out_col_r.b;
  assign out_chan.last_led  = out_last_r;

  // Per-tick decisions, taken from the counters as they stand at acceptance.
  always_comb begin
    per       = (mode_r == rlpe_pkg::MODE_EMERGENCY) ? rlpe_pkg::EMERGENCY_PERIOD : period_r;
    mag       = per[7] ? 8'd0 - per : per;
    do_shift  = (mode_r == rlpe_pkg::MODE_ROTATE) || (mode_r == rlpe_pkg::MODE_EMERGENCY);
    rot_inc   = (rot_r == 8'd255) ? rot_r : rot_r + 8'd1;
    ph1       = phase_r + 8'd1;
    ph_sat    = (phase_r == 8'd255) ? phase_r : ph1;
    grad_new  = (in_chan.level0 != prev_a_r) || (in_chan.level1 != prev_b_r);
    phase_nxt = phase_r;
    rot_nxt   = rot_r;
    delta_nxt = '0;
    tick_nxt  = '0;
    tick_nxt.busy_idx = ph1[6:3];
    tick_nxt.busy_val = ph1 + 8'd80;
    tick_nxt.busy_wrap = ph1[7];
    if (do_shift) begin
      rot_nxt = rot_inc;
      if ((per != 8'd0) && (rot_inc >= mag)) begin
        rot_nxt   = '0;
        delta_nxt = per[7] ? 4'hF : 4'h1;
      end
    end
    unique case (mode_r)
      rlpe_pkg::MODE_ERROR: begin
        tick_nxt.blink_on  = (ph1 == 8'd1);
        tick_nxt.blink_off = (ph1 == 8'd15);
        phase_nxt          = (ph1 == 8'd30) ? 8'd0 : ph1;
      end
      rlpe_pkg::MODE_EMERGENCY: begin
        tick_nxt.paint = (ph_sat == 8'd1);
        phase_nxt      = ph_sat;
      end
      rlpe_pkg::MODE_BUSY: begin
        phase_nxt = ph1[7] ? 8'd0 : ph1;
      end
      rlpe_pkg::MODE_GRADIENT: begin
        tick_nxt.grad_new = grad_new;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rlpe_pkg::MODE_STOP;
      period_r <= '0;
      bat_r    <= '0;
      pal_r    <= '0;
      phase_r  <= '0;
      rot_r    <= '0;
      prev_a_r <= '0;
      prev_b_r <= '0;
      base_r   <= '0;
      delta_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rlpe_pkg::REG_MODE: begin
          mode_r  <= cfg_wdata[3:0];
          phase_r <= '0;
          rot_r   <= '0;
        end
        rlpe_pkg::REG_PERIOD:   period_r <= cfg_wdata;
        rlpe_pkg::REG_BATTERY:  bat_r    <= cfg_wdata[6:0];
        rlpe_pkg::REG_PALETTE0: pal_r[0] <= cfg_wdata[2:0];
        rlpe_pkg::REG_PALETTE1: pal_r[1] <= cfg_wdata[2:0];
        rlpe_pkg::REG_PALETTE2: pal_r[2] <= cfg_wdata[2:0];
        rlpe_pkg::REG_PALETTE3: pal_r[3] <= cfg_wdata[2:0];
        default: mode_r <= mode_r;
      endcase
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      rot_r   <= rot_nxt;
      delta_r <= delta_nxt;
      base_r  <= base_r + delta_nxt;
      if (tick_nxt.grad_new) begin
        prev_a_r <= in_chan.level0;
        prev_b_r <= in_chan.level1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r <= tick_nxt;
      lvl_r  <= {in_chan.level3, in_chan.level2, in_chan.level1, in_chan.level0};
      hd_r   <= {in_chan.heading3, in_chan.heading2, in_chan.heading1, in_chan.heading0};
    end
    if (st_r == ST_SETUP) begin
      chan_r <= chan_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  st_nxt = in_fire ? ST_SETUP : ST_IDLE;
      ST_SETUP: st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_CALC;
      ST_CALC: begin
        if (adv) begin
          st_nxt = (led_r == 4'(rlpe_pkg::LED_COUNT - 1)) ? ST_IDLE : ST_READ;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      led_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_SETUP) begin
        led_r <= '0;
      end else if (adv) begin
        led_r <= led_r + 4'd1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= led_r;
      out_col_r  <= new_col;
      out_last_r <= (led_r == 4'(rlpe_pkg::LED_COUNT - 1));
    end
  end

  rlpe_led_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mode_wr),
    .rd_en   (st_r == ST_READ),
    .rd_addr (phys),
    .rd_data (rd_data),
    .wr_en   (adv),
    .wr_addr (phys),
    .wr_data (new_col)
  );

  rlpe_setup u_setup (
    .lvl  (lvl_r),
    .hd   (hd_r),
    .pal  (pal_r),
    .chan (chan_nxt)
  );

  rlpe_pixel u_pixel (
    .mode    (mode_r),
    .battery (bat_r),
    .tick    (tick_r),
    .chan    (chan_r),
    .oidx    (oidx),
    .old     (rd_data),
    .nxt     (new_col)
  );

  `RLPE_ASSERT_NXT(a_fire_setup, in_fire, st_r == ST_SETUP)
  `RLPE_ASSERT_NXT(a_setup_read, st_r == ST_SETUP, (st_r == ST_READ) && (led_r == 4'd0))
  `RLPE_ASSERT_NXT(a_last_word, adv && (led_r == 4'd15), out_valid_r && out_last_r && (st_r == ST_IDLE))
  `RLPE_ASSERT_NXT(a_mode_clr, mode_wr, (phase_r == 8'd0) && (rot_r == 8'd0))
  `RLPE_ASSERT_IMP(a_idle_only, in_fire, !out_valid_r || out_last_r)

endmodule
